// ===== src/dcr_pkg.sv =====
package dcr_pkg;

    // Default configuration of the block
    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_BLOCK = 1'b1;

endpackage

// ===== src/iq_block_dc_removal_core.sv =====
// Block DC removal for complex I/Q samples.
// Input channel (i_valid / o_stall): each request is either a load (i_op = 0)
// carrying one I/Q pair, or a read (i_op = 1). A load stores the pair in the
// sample buffer and adds it to the running sums; a load with i_last set closes
// the block and starts the mean division. Loads produce no result.
// Output channel (o_valid / i_stall): one result per read request, giving the
// stored sample minus the block mean, saturated, with o_final_out on the last
// sample of the block, or o_status = 1 with zero data when no block is ready.
// Request handling:
//   load          taken back to back while the input is not stalled
//   closing load  stalls the input while two bit-serial dividers, one per
//                 channel, compute both means
//   read          the buffer read is registered, then the corrected sample
//                 enters the output register; the input stalls meanwhile
//   empty read    result is registered on acceptance
// The input is stalled while a read fetch or a division runs, and whenever a
// result sits in the output register with i_stall high; a held result stays
// unchanged until taken.
// Reset (i_rst_n low at a clock edge) clears the sums, count, read index,
// means and block state; buffer contents are left as they are.
module iq_block_dc_removal_core #(
    parameter int MAX_SAMPLES = dcr_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = dcr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_q,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_i,
    output logic signed [SAMPLE_BITS-1:0] o_out_q,
    output logic                          o_final_out,
    output logic                          o_status
);

    localparam int B     = SAMPLE_BITS;
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    // Sums of up to MAX_SAMPLES signed samples, with one guard bit
    localparam int SUM_W = B + AW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]             r_state;
    logic                   r_ready;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_rd_idx;
    logic signed [SUM_W-1:0] r_sum_i;
    logic signed [SUM_W-1:0] r_sum_q;
    logic signed [B-1:0]    r_mean_i;
    logic signed [B-1:0]    r_mean_q;
    logic                   r_final_pend;

    logic                   r_out_vld;
    logic signed [B-1:0]    r_out_i;
    logic signed [B-1:0]    r_out_q;
    logic                   r_out_final;
    logic                   r_out_status;

    logic                   accept;
    logic                   is_load;
    logic                   is_read;
    logic                   read_hit;
    logic [CNT_W-1:0]       eff_cnt;
    logic signed [SUM_W-1:0] eff_sum_i;
    logic signed [SUM_W-1:0] eff_sum_q;
    logic                   has_room;
    logic [CNT_W-1:0]       ld_cnt;
    logic signed [SUM_W-1:0] ld_sum_i;
    logic signed [SUM_W-1:0] ld_sum_q;
    logic                   close_blk;
    logic                   div_start;
    logic                   rd_last;
    logic                   wr_en;
    logic [2*B-1:0]         rd_data;
    logic                   done_i;
    logic                   done_q;
    logic signed [B-1:0]    quo_i;
    logic signed [B-1:0]    quo_q;
    logic signed [B-1:0]    sat_i;
    logic signed [B-1:0]    sat_q;
    logic                   out_free;

    function automatic logic signed [B-1:0] sub_sat(input logic signed [B-1:0] a,
                                                    input logic signed [B-1:0] m);
        logic signed [B:0] d;
        logic signed [B-1:0] res;
        d = {a[B-1], a} - {m[B-1], m};
        if (d[B] != d[B-1]) begin
            res = d[B] ? {1'b1, {(B-1){1'b0}}} : {1'b0, {(B-1){1'b1}}};
        end else begin
            res = d[B-1:0];
        end
        return res;
    endfunction

    // Handshakes: a read needs the output register free at the next edge
    assign out_free = !r_out_vld || !i_stall;
    assign o_stall  = (r_state != ST_IDLE) || (r_out_vld && i_stall);
    assign accept   = i_valid && !o_stall;
    assign is_load  = accept && (i_op == dcr_pkg::OP_LOAD);
    assign is_read  = accept && (i_op == dcr_pkg::OP_READ);
    assign read_hit = r_ready && (r_rd_idx < r_count);
    assign rd_last  = (CNT_W'(r_rd_idx + CNT_W'(1)) == r_count);

    // Load path: a load over a ready block starts from an empty block
    always_comb begin
        eff_cnt   = r_ready ? '0 : r_count;
        eff_sum_i = r_ready ? '0 : r_sum_i;
        eff_sum_q = r_ready ? '0 : r_sum_q;
        has_room  = (eff_cnt < CNT_W'(MAX_SAMPLES));
        ld_cnt    = has_room ? CNT_W'(eff_cnt + CNT_W'(1)) : eff_cnt;
        ld_sum_i  = has_room ? SUM_W'(eff_sum_i + {{(SUM_W-B){i_sample_i[B-1]}}, i_sample_i})
                             : eff_sum_i;
        ld_sum_q  = has_room ? SUM_W'(eff_sum_q + {{(SUM_W-B){i_sample_q[B-1]}}, i_sample_q})
                             : eff_sum_q;
        close_blk = i_last && (ld_cnt != '0);
    end

    assign wr_en     = is_load && has_room;
    assign div_start = is_load && close_blk;

    dcr_ram #(
        .WIDTH (2 * B),
        .DEPTH (MAX_SAMPLES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (eff_cnt[AW-1:0]),
        .i_wr_data ({i_sample_i, i_sample_q}),
        .i_rd_en   (is_read && read_hit),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    dcr_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W),
        .Q_W   (B)
    ) u_div_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ld_sum_i),
        .i_divisor  (ld_cnt),
        .o_done     (done_i),
        .o_quotient (quo_i)
    );

    dcr_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W),
        .Q_W   (B)
    ) u_div_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ld_sum_q),
        .i_divisor  (ld_cnt),
        .o_done     (done_q),
        .o_quotient (quo_q)
    );

    assign sat_i = sub_sat(rd_data[2*B-1:B], r_mean_i);
    assign sat_q = sub_sat(rd_data[B-1:0], r_mean_q);

    // Block state and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ready  <= 1'b0;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_sum_i  <= '0;
            r_sum_q  <= '0;
            r_mean_i <= '0;
            r_mean_q <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (is_load) begin
                        r_count  <= ld_cnt;
                        r_sum_i  <= ld_sum_i;
                        r_sum_q  <= ld_sum_q;
                        r_rd_idx <= '0;
                        r_ready  <= 1'b0;
                        if (close_blk) begin
                            r_state <= ST_DIV;
                        end
                    end else if (is_read && read_hit) begin
                        r_state <= ST_READ;
                        if (rd_last) begin
                            // Drained: drop the block
                            r_ready  <= 1'b0;
                            r_count  <= '0;
                            r_rd_idx <= '0;
                            r_sum_i  <= '0;
                            r_sum_q  <= '0;
                        end else begin
                            r_rd_idx <= CNT_W'(r_rd_idx + CNT_W'(1));
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_IDLE;
                end
                ST_DIV: begin
                    if (done_i && done_q) begin
                        r_mean_i <= quo_i;
                        r_mean_q <= quo_q;
                        r_ready  <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read && read_hit) begin
            r_final_pend <= rd_last;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_READ) begin
            r_out_vld <= 1'b1;
        end else if (is_read && !read_hit) begin
            r_out_vld <= 1'b1;
        end else if (out_free) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_out_i      <= sat_i;
            r_out_q      <= sat_q;
            r_out_final  <= r_final_pend;
            r_out_status <= dcr_pkg::STATUS_OK;
        end else if (is_read && !read_hit) begin
            r_out_i      <= '0;
            r_out_q      <= '0;
            r_out_final  <= 1'b0;
            r_out_status <= dcr_pkg::STATUS_NO_BLOCK;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;
    assign o_final_out = r_out_final;
    assign o_status    = r_out_status;

endmodule

// ===== src/dcr_ram.sv =====
module dcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dcr_div.sv =====
module dcr_div #(
    parameter int DVD_W = 27,
    parameter int DVS_W = 11,
    parameter int Q_W   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic        [DVS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [Q_W-1:0]   o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;

    logic [DVD_W-1:0] dvd_mag;
    logic [DVS_W:0]   shifted;
    logic             fits;
    logic [DVD_W-1:0] quo_signed;

    assign dvd_mag = i_dividend[DVD_W-1] ? (~i_dividend + DVD_W'(1)) : i_dividend;

    // One restoring step per cycle
    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DVD_W-1];
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= dvd_mag;
        end else if (r_busy) begin
            r_rem <= fits ? DVS_W'(shifted - {1'b0, r_dvs}) : shifted[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    // Truncate toward zero: divide magnitudes, restore the sign
    assign quo_signed = r_neg ? (~r_quo + DVD_W'(1)) : r_quo;
    assign o_quotient = quo_signed[Q_W-1:0];
    assign o_done     = r_done;

endmodule

// ===== verif/iq_block_dc_removal_checker.sv =====
`timescale 1ns / 100ps

module iq_block_dc_removal_checker #(
    parameter int MAX_SAMPLES = dcr_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = dcr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic                          i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_q,
    input  logic                          i_last,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_out_i,
    input  logic signed [SAMPLE_BITS-1:0] i_out_q,
    input  logic                          i_final_out,
    input  logic                          i_status,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] out_i;
        logic signed [SAMPLE_BITS-1:0] out_q;
        logic                          final_out;
        logic                          status;
    } t_corrected;

    // Shadow copy of the block state
    logic signed [SAMPLE_BITS-1:0] stored_i [MAX_SAMPLES];
    logic signed [SAMPLE_BITS-1:0] stored_q [MAX_SAMPLES];
    longint                        acc_i;
    longint                        acc_q;
    int                            fill_count;
    int                            drain_index;
    logic signed [SAMPLE_BITS-1:0] dc_i;
    logic signed [SAMPLE_BITS-1:0] dc_q;
    bit                            block_closed;

    t_corrected corrected_queue[$];
    int         fail_total;

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic void restart_block();
        acc_i        = 0;
        acc_q        = 0;
        fill_count   = 0;
        drain_index  = 0;
        block_closed = 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_total++;
    endtask

    task automatic predict_request();
        t_corrected want;
        if (i_op == dcr_pkg::OP_LOAD) begin
            // a load over a closed block discards whatever is left of it
            if (block_closed) restart_block();
            if (fill_count < MAX_SAMPLES) begin
                stored_i[fill_count] = i_sample_i;
                stored_q[fill_count] = i_sample_q;
                acc_i += longint'(i_sample_i);
                acc_q += longint'(i_sample_q);
                fill_count++;
            end
            if (i_last && fill_count > 0) begin
                dc_i         = SAMPLE_BITS'(acc_i / longint'(fill_count));
                dc_q         = SAMPLE_BITS'(acc_q / longint'(fill_count));
                drain_index  = 0;
                block_closed = 1'b1;
            end
        end else if (!block_closed || drain_index >= fill_count) begin
            want = '{out_i: '0, out_q: '0, final_out: 1'b0,
                     status: dcr_pkg::STATUS_NO_BLOCK};
            corrected_queue.push_back(want);
        end else begin
            want.out_i     = clamp_sample(longint'(stored_i[drain_index]) - longint'(dc_i));
            want.out_q     = clamp_sample(longint'(stored_q[drain_index]) - longint'(dc_q));
            want.final_out = (drain_index + 1 == fill_count);
            want.status    = dcr_pkg::STATUS_OK;
            corrected_queue.push_back(want);
            drain_index++;
            if (drain_index >= fill_count) restart_block();
        end
    endtask

    task automatic check_result();
        t_corrected want;
        if (corrected_queue.size() == 0) begin
            report_mismatch($sformatf("result with no read pending: i=%0d q=%0d status=%0b",
                                      i_out_i, i_out_q, i_status));
        end else begin
            want = corrected_queue.pop_front();
            if (i_out_i !== want.out_i)
                report_mismatch($sformatf("out_i %0d, want %0d", i_out_i, want.out_i));
            if (i_out_q !== want.out_q)
                report_mismatch($sformatf("out_q %0d, want %0d", i_out_q, want.out_q));
            if (i_final_out !== want.final_out)
                report_mismatch($sformatf("final_out %0b, want %0b", i_final_out,
                                          want.final_out));
            if (i_status !== want.status)
                report_mismatch($sformatf("status %0b, want %0b", i_status, want.status));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_block();
            dc_i       = '0;
            dc_q       = '0;
            fail_total = 0;
            corrected_queue.delete();
        end else begin
            // requests first, so a result can never overtake its own read
            if (i_req_valid && !i_req_stall) predict_request();
            if (i_rsp_valid && !i_rsp_stall) check_result();
        end
        o_fail_count <= fail_total;
        o_pending    <= corrected_queue.size();
    end

endmodule

// ===== verif/iq_block_dc_removal_core_tb.sv =====
`timescale 1ns / 100ps

module iq_block_dc_removal_core_tb;

    localparam int SW               = dcr_pkg::DEF_SAMPLE_BITS;
    // requests over the whole run, directed ones included
    localparam int REQUEST_TARGET   = 880;
    // worst case is far below this, for a run of ~1000 requests
    localparam int CYCLE_LIMIT      = 500000;
    localparam int LONG_HOLD_CYCLES = 300;
    // covers a trailing mean division plus read latency
    localparam int SETTLE_CYCLES    = 40;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic                 req_op;
    logic signed [SW-1:0] req_sample_i;
    logic signed [SW-1:0] req_sample_q;
    logic                 req_last;
    logic                 rsp_valid;
    logic                 rsp_stall;
    logic signed [SW-1:0] rsp_out_i;
    logic signed [SW-1:0] rsp_out_q;
    logic                 rsp_final_out;
    logic                 rsp_status;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sent_count  = 0;
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;
    bit long_hold   = 1'b0;

    iq_block_dc_removal_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_stall     (req_stall),
        .i_op        (req_op),
        .i_sample_i  (req_sample_i),
        .i_sample_q  (req_sample_q),
        .i_last      (req_last),
        .o_valid     (rsp_valid),
        .i_stall     (rsp_stall),
        .o_out_i     (rsp_out_i),
        .o_out_q     (rsp_out_q),
        .o_final_out (rsp_final_out),
        .o_status    (rsp_status)
    );

    iq_block_dc_removal_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_op         (req_op),
        .i_sample_i   (req_sample_i),
        .i_sample_q   (req_sample_q),
        .i_last       (req_last),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_out_i      (rsp_out_i),
        .i_out_q      (rsp_out_q),
        .i_final_out  (rsp_final_out),
        .i_status     (rsp_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Abort a run that hangs on a handshake
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes it. Valid stays high on
    // return, so a back-to-back request needs no second assignment in this step.
    // Sample stall at the falling edge, where it is settled for the next rising edge.
    task automatic send_request(input logic op, input logic signed [SW-1:0] si,
                                input logic signed [SW-1:0] sq, input logic last);
        int gap;
        bit stalled;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_op       <= op;
        req_sample_i <= si;
        req_sample_q <= sq;
        req_last     <= last;
        do begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end while (stalled);
        sent_count++;
    endtask

    // Reads ignore the sample and last fields; fill them with junk anyway
    task automatic request_read();
        send_request(dcr_pkg::OP_READ, SW'($urandom), SW'($urandom), 1'($urandom));
    endtask

    // Drop valid and hold the sender until every pending read has answered
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mix uniform values, the two extremes and values clustered near a center,
    // so blocks get both small residues and saturating ones
    function automatic logic signed [SW-1:0] draw_sample(input logic signed [SW-1:0] center);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return SW'($urandom);
        if (pick == 6) return S_MAX;
        if (pick == 7) return S_MIN;
        return center + SW'($urandom_range(0, 15)) - SW'(8);
    endfunction

    // Receiver: while rx_idle is set, draw a stall run before every result, and on request hold off
    // for a long stretch so the output register fills and the input backs up
    initial begin
        int gap;
        bit seen;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (long_hold) begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else begin
                gap = rx_idle ? $urandom_range(0, 7) : 0;
                if (gap > 0) begin
                    rsp_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp_stall <= 1'b0;
            do begin
                @(negedge clk);
                seen = rsp_valid;
                @(posedge clk);
            end while (!seen);
            // flip between stalling and free-running now and then
            if ($urandom_range(0, 31) == 0) rx_idle = !rx_idle;
        end
    end

    initial begin
        int                   n;
        int                   kind;
        int                   extra;
        logic signed [SW-1:0] bias_i;
        logic signed [SW-1:0] bias_q;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_op       = dcr_pkg::OP_LOAD;
        req_sample_i = '0;
        req_sample_q = '0;
        req_last     = 1'b0;
        rsp_stall    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // read before any block exists
        request_read();
        // extremes: the means land far enough off that I saturates high, Q low
        send_request(dcr_pkg::OP_LOAD, S_MIN, S_MAX, 1'b0);
        send_request(dcr_pkg::OP_LOAD, S_MIN, S_MAX, 1'b0);
        send_request(dcr_pkg::OP_LOAD, S_MAX, S_MIN, 1'b1);
        // drain all three, then one more on the drained block
        repeat (4) request_read();
        // negative sum: mean truncates toward zero
        send_request(dcr_pkg::OP_LOAD, -SW'(1), SW'(5), 1'b0);
        send_request(dcr_pkg::OP_LOAD, -SW'(2), -SW'(4), 1'b1);
        request_read();
        // load over a half-drained block starts a one-sample block
        send_request(dcr_pkg::OP_LOAD, S_MAX, S_MIN, 1'b1);
        repeat (2) request_read();
        // all-zero single sample
        send_request(dcr_pkg::OP_LOAD, '0, '0, 1'b1);
        request_read();

        // --- back pressure: hold the receiver while reads keep coming ---
        wait_for_drain();
        tx_idle = 1'b0;
        for (int k = 0; k < 16; k++)
            send_request(dcr_pkg::OP_LOAD, SW'($urandom), SW'($urandom), k == 15);
        long_hold = 1'b1;
        repeat (16) request_read();
        wait_for_drain();

        // --- random blocks ---
        while (sent_count < REQUEST_TARGET) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            n       = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(1, 12);
            bias_i  = SW'($urandom);
            bias_q  = SW'($urandom);
            for (int k = 0; k < n; k++)
                send_request(dcr_pkg::OP_LOAD, draw_sample(bias_i), draw_sample(bias_q),
                             k == n - 1);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                repeat (n) request_read();
            end else if (kind == 7) begin
                // leave the block partly read; the next load discards it
                extra = $urandom_range(0, n - 1);
                repeat (extra) request_read();
            end else if (kind == 8) begin
                // read past the end of the block
                extra = $urandom_range(1, 3);
                repeat (n + extra) request_read();
            end else begin
                // noise: loose loads and reads, last only now and then
                extra = $urandom_range(1, 8);
                repeat (extra)
                    send_request(1'($urandom), SW'($urandom), SW'($urandom),
                                 $urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 7) == 0) wait_for_drain();
        end

        // --- wrap up ---
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
